// ===== rtl/deadline_timer_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Deadline timer queue assertion macros
// Shared forms for the concurrent checks of the timer queue controller.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Sizes, codes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package dtq_pkg;

   // Table size and stored tag width.
   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_BITS    = 8;

   // Derived and fixed widths.
   localparam int SLOT_BITS     = $clog2(QUEUE_DEPTH);
   localparam int RESULT_LIMIT  = 16;
   localparam int CNT_BITS      = $clog2(RESULT_LIMIT);
   localparam int TIME_BITS     = 64;
   localparam int DELAY_BITS    = 32;
   localparam int TAG_PORT_BITS = 8;
   localparam int TAG_WIDE_BITS = 16;
   localparam int STATUS_BITS   = 3;

   // Request command codes.
   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_ADDED     = 3'd0,
      ST_NO_ACTION = 3'd1,
      ST_FULL      = 3'd2,
      ST_EXPIRED   = 3'd3,
      ST_NOTHING   = 3'd4
   } status_type;

   // What the result register is loaded with.
   typedef enum logic [1:0] {
      OUT_ADD,
      OUT_PEND_MORE,
      OUT_PEND_LAST,
      OUT_NOTHING
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        scan_step;
      logic        commit;
      logic        out_load;
      out_sel_type out_sel;
   } dtq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic found;
      logic scan_last;
      logic at_limit;
      logic pend_valid;
   } dtq_stat_type;

endpackage

// ===== rtl/dtq_dpath.sv =====
// ----------------------------------------------------------------------------
// Deadline timer queue datapath
// Time counter, slot table, earliest-due scan and the result register.
// ----------------------------------------------------------------------------
module dtq_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dtq_pkg::dtq_cmd_type                 cmd,
   output dtq_pkg::dtq_stat_type                stat,
   input  logic                                 req_cmd,
   input  logic [dtq_pkg::DELAY_BITS-1:0]       req_delay_ms,
   input  logic [dtq_pkg::TAG_PORT_BITS-1:0]    req_action_tag,
   input  logic                                 req_has_action,
   output logic [dtq_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [dtq_pkg::TAG_PORT_BITS-1:0]    rsp_fired_tag,
   output logic [dtq_pkg::TIME_BITS-1:0]        rsp_fired_deadline,
   output logic                                 rsp_last
);
   import dtq_pkg::*;

   // Time counter and captured request.
   logic [TIME_BITS-1:0]     now_ff;
   logic [TIME_BITS-1:0]     now_in;
   logic [DELAY_BITS-1:0]    delay_ff;
   logic [TAG_BITS-1:0]      tag_ff;
   logic                     has_ff;

   // Slot table.
   logic [TIME_BITS-1:0]     slot_dl_ff  [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]      slot_tag_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   slot_valid_ff;

   // Scan state and the held expired entry.
   logic [SLOT_BITS-1:0]     scan_idx_ff;
   logic                     found_ff;
   logic [TIME_BITS-1:0]     best_dl_ff;
   logic [SLOT_BITS-1:0]     best_idx_ff;
   logic [TIME_BITS-1:0]     pend_dl_ff;
   logic [TAG_BITS-1:0]      pend_tag_ff;
   logic                     pend_valid_ff;
   logic [CNT_BITS-1:0]      cnt_ff;

   // Result register.
   status_type               out_status_ff;
   logic [TAG_BITS-1:0]      out_tag_ff;
   logic [TIME_BITS-1:0]     out_dl_ff;
   logic                     out_last_ff;

   // Combinational helpers.
   logic [TAG_WIDE_BITS-1:0] req_tag_wide;
   logic [TAG_WIDE_BITS-1:0] out_tag_wide;
   logic [SLOT_BITS-1:0]     free_idx;
   logic                     full;
   logic [TIME_BITS-1:0]     cur_dl;
   logic                     cur_due;
   logic                     cur_better;
   logic                     scan_last;
   status_type               add_status;
   logic                     add_write;

   // Tags keep their low bits on the way in and are zero-extended on the way out.
   assign req_tag_wide  = TAG_WIDE_BITS'(req_action_tag);
   assign out_tag_wide  = TAG_WIDE_BITS'(out_tag_ff);

   // A tick advances time as it is accepted.
   assign now_in = now_ff + TIME_BITS'(1);

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      full     = 1'b1;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_idx = SLOT_BITS'(i);
            full     = 1'b0;
         end
      end
   end

   // Outcome of an add; a missing action is checked before fullness.
   always_comb begin
      if (!has_ff) begin
         add_status = ST_NO_ACTION;
      end else if (full) begin
         add_status = ST_FULL;
      end else begin
         add_status = ST_ADDED;
      end
   end

   assign add_write = cmd.out_load && (cmd.out_sel == OUT_ADD) && has_ff && !full;

   // One slot is examined per scan cycle; strict compare keeps the lowest slot on ties.
   assign cur_dl     = slot_dl_ff[scan_idx_ff];
   assign cur_due    = slot_valid_ff[scan_idx_ff] && (cur_dl < now_ff);
   assign cur_better = !found_ff || (cur_dl < best_dl_ff);
   assign scan_last  = (scan_idx_ff == SLOT_BITS'(QUEUE_DEPTH - 1));

   // Status toward the controller.
   assign stat.found      = found_ff;
   assign stat.scan_last  = scan_last;
   assign stat.at_limit   = (cnt_ff == CNT_BITS'(RESULT_LIMIT - 1));
   assign stat.pend_valid = pend_valid_ff;

   // Valid bits: set by an add, cleared when an entry fires.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else begin
         if (add_write) begin
            slot_valid_ff[free_idx] <= 1'b1;
         end
         if (cmd.commit) begin
            slot_valid_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   // Slot payload is written only by an accepted add.
   always_ff @(posedge clock) begin
      if (add_write) begin
         slot_dl_ff[free_idx]  <= now_ff + TIME_BITS'(delay_ff);
         slot_tag_ff[free_idx] <= tag_ff;
      end
   end

   // Time counter and scan control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         scan_idx_ff   <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else if (cmd.capture) begin
         if (req_cmd == CMD_TICK) begin
            now_ff <= now_in;
         end
         scan_idx_ff   <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
      end else if (cmd.commit) begin
         scan_idx_ff   <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b1;
         cnt_ff        <= cnt_ff + CNT_BITS'(1);
      end else if (cmd.scan_step) begin
         if (!scan_last) begin
            scan_idx_ff <= scan_idx_ff + SLOT_BITS'(1);
         end
         if (cur_due && cur_better) begin
            found_ff <= 1'b1;
         end
      end
   end

   // Captured request fields, best candidate and held entry.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         delay_ff <= req_delay_ms;
         tag_ff   <= req_tag_wide[TAG_BITS-1:0];
         has_ff   <= req_has_action;
      end
      if (cmd.scan_step && cur_due && cur_better) begin
         best_dl_ff  <= cur_dl;
         best_idx_ff <= scan_idx_ff;
      end
      if (cmd.commit) begin
         pend_dl_ff  <= best_dl_ff;
         pend_tag_ff <= slot_tag_ff[best_idx_ff];
      end
   end

   // Result register; the held entry is read before a commit replaces it.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         case (cmd.out_sel)
            OUT_ADD: begin
               out_status_ff <= add_status;
               out_tag_ff    <= '0;
               out_dl_ff     <= '0;
               out_last_ff   <= 1'b1;
            end
            OUT_PEND_MORE: begin
               out_status_ff <= ST_EXPIRED;
               out_tag_ff    <= pend_tag_ff;
               out_dl_ff     <= pend_dl_ff;
               out_last_ff   <= 1'b0;
            end
            OUT_PEND_LAST: begin
               out_status_ff <= ST_EXPIRED;
               out_tag_ff    <= pend_tag_ff;
               out_dl_ff     <= pend_dl_ff;
               out_last_ff   <= 1'b1;
            end
            default: begin
               out_status_ff <= ST_NOTHING;
               out_tag_ff    <= '0;
               out_dl_ff     <= '0;
               out_last_ff   <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_status         = out_status_ff;
   assign rsp_fired_tag      = out_tag_wide[TAG_PORT_BITS-1:0];
   assign rsp_fired_deadline = out_dl_ff;
   assign rsp_last           = out_last_ff;

endmodule

// ===== rtl/dtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Deadline timer queue controller
// Sequences adds, repeated earliest-due scans and the result handshake.
// ----------------------------------------------------------------------------
`include "deadline_timer_queue_assert.svh"

module dtq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dtq_pkg::dtq_cmd_type  cmd,
   input  dtq_pkg::dtq_stat_type stat
);
   import dtq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_SCAN,
      S_EMIT,
      S_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // The result register can take a new value when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.scan_step = 1'b0;
      cmd.commit    = 1'b0;
      cmd.out_load  = 1'b0;
      cmd.out_sel   = OUT_NOTHING;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_cmd == CMD_TICK) ? S_SCAN : S_ADD;
            end
         end
         S_ADD: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ADD;
               state_in     = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // A found entry is held until the next scan tells whether it is the last.
            if (out_free) begin
               if (stat.found) begin
                  cmd.commit   = 1'b1;
                  cmd.out_load = stat.pend_valid;
                  cmd.out_sel  = OUT_PEND_MORE;
                  state_in     = stat.at_limit ? S_FLUSH : S_SCAN;
               end else begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = stat.pend_valid ? OUT_PEND_LAST : OUT_NOTHING;
                  state_in     = S_IDLE;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_PEND_LAST;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);

   // State and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A waiting result is never replaced before it is taken.
   `DTQ_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_load, out_free, "result overwritten while stalled")
   // An entry is only retired when the scan found one.
   `DTQ_ASSERT_NOW(a_commit_found, clock, reset, cmd.commit, stat.found, "commit without a due entry")
   // An accepted request always starts an add or a scan.
   `DTQ_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == S_ADD || state_ff == S_SCAN, "accepted request did not start work")

endmodule

// ===== rtl/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// Deadline timer queue
// One-shot timer table with a millisecond counter and earliest-first expiry.
// ----------------------------------------------------------------------------
// An add request is accepted and its single result is then loaded into the
// output register once that register is free. A tick request scans the slot
// table once per expired entry, and once more that finds none unless 16 have
// fired, one slot per cycle through a due compare and a best-so-far compare.
// A tick fires at most 16 entries. One request is worked on at a time, and
// output stalls hold it up. Each result holds the earliest due deadline
// first, ties going to the lowest slot, and the final result of a request
// carries rsp_last.
module deadline_timer_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_cmd,
   input  logic [dtq_pkg::DELAY_BITS-1:0]    req_delay_ms,
   input  logic [dtq_pkg::TAG_PORT_BITS-1:0] req_action_tag,
   input  logic                              req_has_action,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dtq_pkg::STATUS_BITS-1:0]   rsp_status,
   output logic [dtq_pkg::TAG_PORT_BITS-1:0] rsp_fired_tag,
   output logic [dtq_pkg::TIME_BITS-1:0]     rsp_fired_deadline,
   output logic                              rsp_last
);
   import dtq_pkg::*;

   dtq_cmd_type  cmd;
   dtq_stat_type stat;

   // Sequencer.
   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Table, time counter and result register.
   dtq_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_cmd            (req_cmd),
      .req_delay_ms       (req_delay_ms),
      .req_action_tag     (req_action_tag),
      .req_has_action     (req_has_action),
      .rsp_status         (rsp_status),
      .rsp_fired_tag      (rsp_fired_tag),
      .rsp_fired_deadline (rsp_fired_deadline),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== test/deadline_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Drives add and tick requests through the valid/stall request channel and
// checks every result against an in-bench model of the timer table.
// ----------------------------------------------------------------------------
// A directed opening covers null actions, a full table, a tick that fires
// every slot at once with tied deadlines, the widest delay and an empty tick.
// A random phase follows with bursty requests, a stalling receiver and one
// pause that lets the result queue drain completely.
module deadline_timer_queue_tb;
   import dtq_pkg::*;

   localparam int RANDOM_REQUESTS = 100;
   localparam int MAX_BIG_DELAYS  = 2;
   localparam int SETTLE_CYCLES   = 40;

   // Expected-result store and timer table model.
   class expiry_scoreboard;
      typedef struct {
         status_type               status;
         logic [TAG_PORT_BITS-1:0] tag;
         logic [TIME_BITS-1:0]     deadline;
         logic                     last;
      } timer_result_type;

      logic [TIME_BITS-1:0] now_ms = '0;
      logic [TIME_BITS-1:0] slot_deadline [QUEUE_DEPTH];
      logic [TAG_BITS-1:0]  slot_tag [QUEUE_DEPTH];
      bit                   slot_busy [QUEUE_DEPTH];
      timer_result_type     expected_results [$];

      int error_count;
      int added_count;
      int rejected_count;
      int expired_count;
      int idle_tick_count;
      int busiest_tick;

      function void push_result(status_type status, logic [TAG_PORT_BITS-1:0] tag,
                                logic [TIME_BITS-1:0] deadline, logic last);
         timer_result_type r;
         r.status   = status;
         r.tag      = tag;
         r.deadline = deadline;
         r.last     = last;
         expected_results.push_back(r);
      endfunction

      // Work out the results that one accepted request causes.
      function void note_request(logic cmd, logic [DELAY_BITS-1:0] delay_ms,
                                 logic [TAG_PORT_BITS-1:0] action_tag, logic has_action);
         int               free_slot;
         int               best;
         int               fired;
         timer_result_type r;
         free_slot = -1;
         if (cmd == CMD_ADD) begin
            if (!has_action) begin
               // A null action is refused before the table is looked at.
               push_result(ST_NO_ACTION, '0, '0, 1'b1);
               rejected_count++;
            end else begin
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (!slot_busy[i] && free_slot < 0) begin
                     free_slot = i;
                  end
               end
               if (free_slot < 0) begin
                  push_result(ST_FULL, '0, '0, 1'b1);
                  rejected_count++;
               end else begin
                  slot_deadline[free_slot] = now_ms + TIME_BITS'(delay_ms);
                  slot_tag[free_slot]      = action_tag[TAG_BITS-1:0];
                  slot_busy[free_slot]     = 1'b1;
                  push_result(ST_ADDED, '0, '0, 1'b1);
                  added_count++;
               end
            end
         end else begin
            // Advance time, then fire due entries earliest first, lowest slot on ties.
            now_ms = now_ms + 1'b1;
            fired  = 0;
            best   = 0;
            while (fired < RESULT_LIMIT && best >= 0) begin
               best = -1;
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (slot_busy[i] && slot_deadline[i] < now_ms) begin
                     if (best < 0) begin
                        best = i;
                     end else if (slot_deadline[i] < slot_deadline[best]) begin
                        best = i;
                     end
                  end
               end
               if (best >= 0) begin
                  slot_busy[best] = 1'b0;
                  push_result(ST_EXPIRED, TAG_PORT_BITS'(slot_tag[best]),
                              slot_deadline[best], 1'b0);
                  fired++;
               end
            end
            if (fired == 0) begin
               push_result(ST_NOTHING, '0, '0, 1'b1);
               idle_tick_count++;
            end else begin
               r = expected_results.pop_back();
               r.last = 1'b1;
               expected_results.push_back(r);
               expired_count += fired;
               if (fired > busiest_tick) begin
                  busiest_tick = fired;
               end
            end
         end
      endfunction

      // Compare one accepted result with the oldest expectation.
      function void check_result(logic [STATUS_BITS-1:0] status,
                                 logic [TAG_PORT_BITS-1:0] tag,
                                 logic [TIME_BITS-1:0] deadline, logic last);
         timer_result_type want;
         if (expected_results.size() == 0) begin
            $error("result with no request waiting: status %0d, tag %0d", status, tag);
            error_count++;
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status) begin
            $error("rsp_status: expected %0d, got %0d", want.status, status);
            error_count++;
         end
         if (tag !== want.tag) begin
            $error("rsp_fired_tag: expected %0h, got %0h", want.tag, tag);
            error_count++;
         end
         if (deadline !== want.deadline) begin
            $error("rsp_fired_deadline: expected %0h, got %0h", want.deadline, deadline);
            error_count++;
         end
         if (last !== want.last) begin
            $error("rsp_last: expected %0b, got %0b", want.last, last);
            error_count++;
         end
      endfunction
   endclass

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_cmd        = CMD_ADD;
   logic [DELAY_BITS-1:0]    req_delay_ms   = '0;
   logic [TAG_PORT_BITS-1:0] req_action_tag = '0;
   logic                     req_has_action = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic [STATUS_BITS-1:0]   rsp_status;
   logic [TAG_PORT_BITS-1:0] rsp_fired_tag;
   logic [TIME_BITS-1:0]     rsp_fired_deadline;
   logic                     rsp_last;

   expiry_scoreboard sb = new();
   int               big_delays = 0;
   int               stall_mode = 0;
   int               stall_left = 0;

   deadline_timer_queue dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_delay_ms       (req_delay_ms),
      .req_action_tag     (req_action_tag),
      .req_has_action     (req_has_action),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_fired_tag      (rsp_fired_tag),
      .rsp_fired_deadline (rsp_fired_deadline),
      .rsp_last           (rsp_last)
   );

   always #5 clock = ~clock;

   // Receiver stall pattern: switches between free flow, random, alternating
   // and long stall runs, in modes picked at random.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 60);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 99) < 30);
         end
         2: begin
            rsp_stall <= ~rsp_stall;
         end
         default: begin
            rsp_stall <= ((stall_left % 16) < 10);
         end
      endcase
   end

   // Check every accepted result.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_status, rsp_fired_tag, rsp_fired_deadline, rsp_last);
      end
   end

   // Present one request and hold it until the block takes it.
   task automatic send_request(input logic cmd, input logic [DELAY_BITS-1:0] delay_ms,
                               input logic [TAG_PORT_BITS-1:0] action_tag,
                               input logic has_action);
      @(negedge clock);
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_delay_ms   <= delay_ms;
      req_action_tag <= action_tag;
      req_has_action <= has_action;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_request(cmd, delay_ms, action_tag, has_action);
   endtask

   // Leave the request channel idle for a number of cycles.
   task automatic pause_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Leave the request channel idle until every expected result has come.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(negedge clock);
   endtask

   // Mostly short timers and ticks, with a few null actions and wide delays.
   task automatic random_request();
      int                       pick;
      logic [TAG_PORT_BITS-1:0] tag;
      pick = $urandom_range(0, 99);
      tag  = TAG_PORT_BITS'($urandom_range(0, 255));
      if (pick < 40) begin
         send_request(CMD_TICK, $urandom, tag, 1'($urandom_range(0, 1)));
      end else if (pick < 45) begin
         send_request(CMD_ADD, $urandom, tag, 1'b0);
      end else if (pick < 48 && big_delays < MAX_BIG_DELAYS) begin
         big_delays++;
         send_request(CMD_ADD, $urandom, tag, 1'b1);
      end else begin
         send_request(CMD_ADD, $urandom_range(0, 8), tag, 1'b1);
      end
   endtask

   initial begin
      int burst;
      int gap;
      burst = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: empty tick, null action, then fill the table.
      send_request(CMD_TICK, 32'h0, 8'h00, 1'b0);
      send_request(CMD_ADD, 32'hFFFF_FFFF, 8'hFF, 1'b0);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_request(CMD_ADD, 32'd0,
                      (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                      1'b1);
      end
      // Full table, and a null action that must win over the full check.
      send_request(CMD_ADD, 32'd3, 8'h5A, 1'b1);
      send_request(CMD_ADD, 32'd3, 8'h5A, 1'b0);
      // All sixteen deadlines tie, so one tick fires them in slot order.
      send_request(CMD_TICK, $urandom, 8'hFF, 1'b1);
      // The widest delay stays pending for the rest of the run.
      send_request(CMD_ADD, 32'hFFFF_FFFF, 8'hA5, 1'b1);
      send_request(CMD_ADD, 32'd1, 8'h3C, 1'b1);
      send_request(CMD_TICK, 32'h0, 8'h00, 1'b0);
      send_request(CMD_TICK, 32'h0, 8'h00, 1'b0);

      // Random phase in bursts, with one full drain halfway through.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 10);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               pause_sender(gap);
            end
         end
         if (n == RANDOM_REQUESTS / 2) begin
            drain_results();
         end
         random_request();
         burst--;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d stored timers, %0d refused adds and %0d expiries",
               sb.added_count, sb.rejected_count, sb.expired_count);
      $display("(at most %0d in one tick), plus %0d ticks with nothing due.",
               sb.busiest_tick, sb.idle_tick_count);
      if (sb.error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
